@@ rtl/core/itb_pkg.sv @@
// Shared types and constants of the image transpose buffer.
package itb_pkg;

    localparam int CNT_W      = 9;
    localparam int STEP_W     = CNT_W + 1;
    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int NIB_W      = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE_MODE  = 2'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_NOT_LOADED = 2'd1;
    localparam logic [1:0] STATUS_FULL       = 2'd2;

    localparam logic [7:0] NIB_MASK  = 8'd15;
    localparam int         NIB_SHIFT = 4;
    localparam logic [7:0] GREY_MIN  = 8'd0;
    localparam logic [7:0] GREY_MAX  = 8'd255;
    localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;

    typedef enum logic [1:0] {
        OP_REPORT,
        OP_LOAD,
        OP_FETCH
    } op_kind_t;

    typedef struct packed {
        logic       command;
        logic [7:0] load_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
        logic [1:0] status;
        logic [7:0] min_grey;
        logic [7:0] max_grey;
    } result_t;

    typedef struct packed {
        op_kind_t         kind;
        logic             nibble;
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
        logic [7:0]       data;
        logic             lo_ok;
        logic             last_byte;
        logic [1:0]       status;
        logic [7:0]       min_grey;
        logic [7:0]       max_grey;
    } op_t;

endpackage

@@ rtl/core/itb_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
module itb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end

endmodule

@@ rtl/core/itb_queue.sv @@
// Short operation queue between the front end and the back end.
module itb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  itb_pkg::op_t  din,
    input  logic          pop,
    output itb_pkg::op_t  dout,
    output logic          full,
    output logic          empty
);

    localparam int D   = itb_pkg::QUEUE_DEPTH;
    localparam int PW  = (D > 1) ? $clog2(D) : 1;
    localparam int CW  = $clog2(D + 1);

    itb_pkg::op_t  mem_reg [D];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CW'(D));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(D - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(D - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

@@ rtl/core/itb_front.sv @@
// Front end: configuration, counters, grey statistics and command classification.
module itb_front #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  itb_pkg::item_t                    item,
    input  logic                              full,
    output logic                              push,
    output itb_pkg::op_t                      op,
    input  logic                              cfg_we,
    input  logic [itb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [itb_pkg::CFG_W-1:0]         cfg_data
);

    localparam int CN = itb_pkg::CNT_W;
    localparam int SN = itb_pkg::STEP_W;

    logic [itb_pkg::CFG_W-1:0] width_reg, height_reg;
    logic                      nibble_reg;
    logic [CN-1:0] load_row_reg, load_row_next;
    logic [CN-1:0] load_col_reg, load_col_next;
    logic [CN-1:0] emit_row_reg, emit_row_next;
    logic [CN-1:0] emit_col_reg, emit_col_next;
    logic          loaded_reg, loaded_next;
    logic [7:0]    least_reg, least_next;
    logic [7:0]    greatest_reg, greatest_next;

    logic [CN-1:0] w_eff, h_eff;
    logic [SN-1:0] col_step, row_step, col_inc;
    logic [CN-1:0] row_inc;
    logic [7:0]    base_min, base_max;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = CN'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            w_eff = CN'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end
        if (height_reg == '0)
        begin
            h_eff = CN'(1);
        end
        else if (int'(height_reg) > MAX_HEIGHT)
        begin
            h_eff = CN'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    assign push = start && !full;

    always_comb
    begin
        load_row_next = load_row_reg;
        load_col_next = load_col_reg;
        emit_row_next = emit_row_reg;
        emit_col_next = emit_col_reg;
        loaded_next   = loaded_reg;
        least_next    = least_reg;
        greatest_next = greatest_reg;
        base_min      = least_reg;
        base_max      = greatest_reg;
        col_step      = '0;
        row_step      = '0;
        col_inc       = '0;
        row_inc       = '0;
        op            = '0;
        op.kind       = itb_pkg::OP_REPORT;
        op.nibble     = nibble_reg;
        op.data       = item.load_byte;
        op.status     = itb_pkg::STATUS_OK;
        if (push)
        begin
            if (item.command == itb_pkg::CMD_LOAD)
            begin
                if (loaded_reg)
                begin
                    op.status = itb_pkg::STATUS_FULL;
                end
                else
                begin
                    op.kind  = itb_pkg::OP_LOAD;
                    op.row   = load_row_reg;
                    op.col   = load_col_reg;
                    op.lo_ok = ({1'b0, load_col_reg} + SN'(1)) < {1'b0, w_eff};
                    if (load_row_reg == '0 && load_col_reg == '0)
                    begin
                        base_min = itb_pkg::GREY_MAX;
                        base_max = itb_pkg::GREY_MIN;
                    end
                    least_next    = base_min;
                    greatest_next = base_max;
                    if (!nibble_reg)
                    begin
                        if (item.load_byte < base_min)
                        begin
                            least_next = item.load_byte;
                        end
                        if (item.load_byte > base_max)
                        begin
                            greatest_next = item.load_byte;
                        end
                        col_step = {1'b0, load_col_reg} + SN'(1);
                    end
                    else
                    begin
                        col_step = {1'b0, load_col_reg} + SN'(2);
                    end
                    if (col_step >= {1'b0, w_eff})
                    begin
                        load_col_next = '0;
                        row_inc = load_row_reg + 1'b1;
                        if (row_inc >= h_eff || row_inc == '0)
                        begin
                            loaded_next   = 1'b1;
                            load_row_next = '0;
                            emit_row_next = '0;
                            emit_col_next = '0;
                        end
                        else
                        begin
                            load_row_next = row_inc;
                        end
                    end
                    else
                    begin
                        load_col_next = col_step[CN-1:0];
                    end
                end
            end
            else
            begin
                if (!loaded_reg)
                begin
                    op.status = itb_pkg::STATUS_NOT_LOADED;
                end
                else
                begin
                    op.kind  = itb_pkg::OP_FETCH;
                    op.row   = emit_row_reg;
                    op.col   = emit_col_reg;
                    op.lo_ok = ({1'b0, emit_row_reg} + SN'(1)) < {1'b0, h_eff};
                    row_step = {1'b0, emit_row_reg} + (nibble_reg ? SN'(2) : SN'(1));
                    if (row_step >= {1'b0, h_eff})
                    begin
                        emit_row_next = '0;
                        col_inc = {1'b0, emit_col_reg} + SN'(1);
                        if (col_inc >= {1'b0, w_eff})
                        begin
                            op.last_byte  = 1'b1;
                            loaded_next   = 1'b0;
                            emit_col_next = '0;
                        end
                        else
                        begin
                            emit_col_next = col_inc[CN-1:0];
                        end
                    end
                    else
                    begin
                        emit_row_next = row_step[CN-1:0];
                    end
                end
            end
        end
        op.min_grey = least_next;
        op.max_grey = greatest_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= itb_pkg::SIZE_RESET;
            height_reg   <= itb_pkg::SIZE_RESET;
            nibble_reg   <= 1'b0;
            load_row_reg <= '0;
            load_col_reg <= '0;
            emit_row_reg <= '0;
            emit_col_reg <= '0;
            loaded_reg   <= 1'b0;
            least_reg    <= itb_pkg::GREY_MAX;
            greatest_reg <= itb_pkg::GREY_MIN;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    itb_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    itb_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    itb_pkg::CFG_NIBBLE_MODE:  nibble_reg <= cfg_data[0];
                    default:                   ;
                endcase
            end
            load_row_reg <= load_row_next;
            load_col_reg <= load_col_next;
            emit_row_reg <= emit_row_next;
            emit_col_reg <= emit_col_next;
            loaded_reg   <= loaded_next;
            least_reg    <= least_next;
            greatest_reg <= greatest_next;
        end
    end

endmodule

@@ rtl/core/itb_back.sv @@
// Back end: pixel store accesses and result beat generation.
module itb_back #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  itb_pkg::op_t      head,
    input  logic              empty,
    output logic              pop,
    output logic              done,
    output itb_pkg::result_t  result
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = AW + itb_pkg::STEP_W + 1;
    localparam int SN    = itb_pkg::STEP_W;
    localparam int NW    = itb_pkg::NIB_W;

    typedef enum logic [1:0] {
        B_IDLE,
        B_EXEC,
        B_WR2,
        B_READ
    } state_t;

    state_t           state_reg, state_next;
    logic             done_reg, done_next;
    itb_pkg::result_t result_reg, result_next;
    itb_pkg::op_t     op_reg;

    logic [SN-1:0] row_ext, col_ext, row_lo, col_lo;
    logic [PW-1:0] base_addr;
    logic          ok_a, ok_b, ok_w2;
    logic          we;
    logic [AW-1:0] waddr, raddr_a, raddr_b;
    logic [7:0]    wdata, rdata_a, rdata_b, fetched;
    itb_pkg::result_t res_base;

    assign row_ext   = {1'b0, op_reg.row};
    assign col_ext   = {1'b0, op_reg.col};
    assign row_lo    = row_ext + SN'(1);
    assign col_lo    = col_ext + SN'(1);
    assign base_addr = PW'(row_ext) * PW'(MAX_WIDTH) + PW'(col_ext);
    assign ok_a      = int'(row_ext) < MAX_HEIGHT && int'(col_ext) < MAX_WIDTH;
    assign ok_b      = int'(row_lo) < MAX_HEIGHT && int'(col_ext) < MAX_WIDTH;
    assign ok_w2     = int'(row_ext) < MAX_HEIGHT && int'(col_lo) < MAX_WIDTH;

    assign raddr_a = base_addr[AW-1:0];
    assign raddr_b = AW'(base_addr + PW'(MAX_WIDTH));

    always_comb
    begin
        we    = 1'b0;
        waddr = base_addr[AW-1:0];
        wdata = op_reg.nibble ? (op_reg.data >> itb_pkg::NIB_SHIFT) : op_reg.data;
        if (state_reg == B_EXEC && op_reg.kind == itb_pkg::OP_LOAD)
        begin
            we = ok_a;
        end
        else if (state_reg == B_WR2)
        begin
            we    = ok_w2;
            waddr = AW'(base_addr + PW'(1));
            wdata = op_reg.data & itb_pkg::NIB_MASK;
        end
    end

    always_comb
    begin
        if (op_reg.nibble)
        begin
            fetched = {ok_a ? rdata_a[NW-1:0] : NW'(0),
                       (op_reg.lo_ok && ok_b) ? rdata_b[NW-1:0] : NW'(0)};
        end
        else
        begin
            fetched = ok_a ? rdata_a : 8'd0;
        end
    end

    always_comb
    begin
        res_base.out_byte  = 8'd0;
        res_base.last_byte = op_reg.last_byte;
        res_base.status    = op_reg.status;
        res_base.min_grey  = op_reg.min_grey;
        res_base.max_grey  = op_reg.max_grey;
    end

    assign pop = (state_reg == B_IDLE) && !empty;

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    state_next = B_EXEC;
                end
            end
            B_EXEC:
            begin
                case (op_reg.kind)
                    itb_pkg::OP_LOAD:
                    begin
                        if (op_reg.nibble && op_reg.lo_ok)
                        begin
                            state_next = B_WR2;
                        end
                        else
                        begin
                            done_next   = 1'b1;
                            result_next = res_base;
                            state_next  = B_IDLE;
                        end
                    end
                    itb_pkg::OP_FETCH:
                    begin
                        state_next = B_READ;
                    end
                    default:
                    begin
                        done_next   = 1'b1;
                        result_next = res_base;
                        state_next  = B_IDLE;
                    end
                endcase
            end
            B_WR2:
            begin
                done_next   = 1'b1;
                result_next = res_base;
                state_next  = B_IDLE;
            end
            B_READ:
            begin
                done_next            = 1'b1;
                result_next          = res_base;
                result_next.out_byte = fetched;
                state_next           = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg <= head;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    itb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

endmodule

@@ rtl/core/image_transpose_buffer_top.sv @@
// Top level of the image transpose buffer.
//
// A load or fetch command is taken when start is high and busy is low; busy
// rises only while the two-entry command queue is full. Each command yields
// exactly one result beat, marked by done for a single cycle, which must be
// captured then since it cannot be held off. The back end takes a command
// from the queue only while idle and finishes it before taking the next: an
// 8-bit load, a 4-bit load that writes a single pixel or a rejected command
// needs only the execute state, while a 4-bit load that writes two pixels
// adds a second write state and a fetch adds a read state, set by the single
// write port of the pixel store and its registered read.
// The pixel store holds MAX_WIDTH times MAX_HEIGHT bytes and is not cleared.
module image_transpose_buffer_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  itb_pkg::item_t                 item,
    output logic                           done,
    output itb_pkg::result_t               result,
    input  logic                           cfg_we,
    input  logic [itb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [itb_pkg::CFG_W-1:0]      cfg_data
);

    logic         push, pop, full, empty;
    itb_pkg::op_t op_in, op_head;

    assign busy = full;

    itb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .full      (full),
        .push      (push),
        .op        (op_in),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    itb_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (op_in),
        .pop   (pop),
        .dout  (op_head),
        .full  (full),
        .empty (empty)
    );

    itb_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (op_head),
        .empty  (empty),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the image transpose buffer: random and directed beats.
module tb;
    import itb_pkg::*;

    localparam int DIM_MAX     = 256;
    localparam int CNT_MASK    = 'h1FF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int BEAT_TARGET = 860;

    typedef enum int {
        PHASE_SMALL,
        PHASE_WIDE,
        PHASE_TALL
    } phase_kind_t;

    typedef struct packed {
        logic  drain;
        item_t beat;
    } pending_beat_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    item_t                item;
    logic                 done;
    result_t              result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    pending_beat_t command_queue[$];
    pending_beat_t next_beat;
    result_t       queued_outputs[$];
    result_t       next_result;
    result_t       want;

    logic [7:0]       pixels [0:DIM_MAX*DIM_MAX-1];
    logic [CFG_W-1:0] cfg_width;
    logic [CFG_W-1:0] cfg_height;
    logic             cfg_nibble;
    int               ld_row;
    int               ld_col;
    int               em_row;
    int               em_col;
    logic             img_full;
    logic [7:0]       grey_lo;
    logic [7:0]       grey_hi;

    int gap_left;
    int gap_style;
    int mismatch_count;
    int cycle_count;
    int beats_queued;

    image_transpose_buffer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int eff_dim(logic [CFG_W-1:0] r);
        if (r == 0)
        begin
            return 1;
        end
        if (r > DIM_MAX)
        begin
            return DIM_MAX;
        end
        return int'(r);
    endfunction

    function automatic void pix_put(int r, int c, logic [7:0] v);
        if (r < DIM_MAX && c < DIM_MAX)
        begin
            pixels[r*DIM_MAX+c] = v;
        end
    endfunction

    function automatic logic [7:0] pix_get(int r, int c);
        if (r < DIM_MAX && c < DIM_MAX)
        begin
            return pixels[r*DIM_MAX+c];
        end
        return 8'd0;
    endfunction

    task automatic predict_transpose(input item_t beat, output result_t res);
        int         w;
        int         h;
        int         r;
        int         c;
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] obyte;
        logic       last;
        logic [1:0] stat;
        w     = eff_dim(cfg_width);
        h     = eff_dim(cfg_height);
        obyte = 8'd0;
        last  = 1'b0;
        stat  = STATUS_OK;
        if (beat.command == CMD_LOAD)
        begin
            if (img_full)
            begin
                stat = STATUS_FULL;
            end
            else
            begin
                if (ld_row == 0 && ld_col == 0)
                begin
                    grey_lo = GREY_MAX;
                    grey_hi = GREY_MIN;
                end
                if (!cfg_nibble)
                begin
                    pix_put(ld_row, ld_col, beat.load_byte);
                    if (beat.load_byte < grey_lo)
                    begin
                        grey_lo = beat.load_byte;
                    end
                    if (beat.load_byte > grey_hi)
                    begin
                        grey_hi = beat.load_byte;
                    end
                    ld_col = ld_col + 1;
                end
                else
                begin
                    pix_put(ld_row, ld_col, beat.load_byte >> NIB_SHIFT);
                    if (ld_col + 1 < w)
                    begin
                        pix_put(ld_row, ld_col + 1, beat.load_byte & NIB_MASK);
                    end
                    ld_col = ld_col + 2;
                end
                if (ld_col >= w)
                begin
                    ld_col = 0;
                    ld_row = (ld_row + 1) & CNT_MASK;
                    if (ld_row >= h || ld_row == 0)
                    begin
                        img_full = 1'b1;
                        ld_row   = 0;
                        em_row   = 0;
                        em_col   = 0;
                    end
                end
            end
        end
        else
        begin
            if (!img_full)
            begin
                stat = STATUS_NOT_LOADED;
            end
            else
            begin
                r = em_row;
                c = em_col;
                if (!cfg_nibble)
                begin
                    obyte = pix_get(r, c);
                    r     = r + 1;
                end
                else
                begin
                    hi    = pix_get(r, c) & NIB_MASK;
                    lo    = (r + 1 < h) ? (pix_get(r + 1, c) & NIB_MASK) : 8'd0;
                    obyte = (hi << NIB_SHIFT) | lo;
                    r     = r + 2;
                end
                if (r >= h)
                begin
                    r = 0;
                    c = c + 1;
                    if (c >= w)
                    begin
                        last     = 1'b1;
                        img_full = 1'b0;
                        c        = 0;
                    end
                end
                em_row = r & CNT_MASK;
                em_col = c & CNT_MASK;
            end
        end
        res.out_byte  = obyte;
        res.last_byte = last;
        res.status    = stat;
        res.min_grey  = grey_lo;
        res.max_grey  = grey_hi;
    endtask

    task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] exp_val);
        $display("ERROR %s: got %0h, expected %0h", field, got, exp_val);
        mismatch_count++;
    endtask

    function automatic int draw_gap();
        int roll;
        if (gap_style == 0)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            item     <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_transpose(item, next_result);
                queued_outputs.push_back(next_result);
            end
            if (start && busy)
            begin
                start <= 1'b1;
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end
            else if (command_queue.size() != 0 &&
                     (!command_queue[0].drain || queued_outputs.size() == 0))
            begin
                next_beat = command_queue.pop_front();
                item     <= next_beat.beat;
                start    <= 1'b1;
                gap_left <= draw_gap();
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (queued_outputs.size() == 0)
            begin
                report_mismatch("unexpected beat", result.out_byte, 8'd0);
            end
            else
            begin
                want = queued_outputs.pop_front();
                if (result.out_byte !== want.out_byte)
                begin
                    report_mismatch("out_byte", result.out_byte, want.out_byte);
                end
                if (result.last_byte !== want.last_byte)
                begin
                    report_mismatch("last_byte", 8'(result.last_byte), 8'(want.last_byte));
                end
                if (result.status !== want.status)
                begin
                    report_mismatch("status", 8'(result.status), 8'(want.status));
                end
                if (result.min_grey !== want.min_grey)
                begin
                    report_mismatch("min_grey", result.min_grey, want.min_grey);
                end
                if (result.max_grey !== want.max_grey)
                begin
                    report_mismatch("max_grey", result.max_grey, want.max_grey);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("image_transpose_buffer_top: mismatch");
            $finish;
        end
    end

    task automatic push_beat(logic cmd, logic [7:0] data, logic wait_drain);
        pending_beat_t p;
        p.drain          = wait_drain;
        p.beat.command   = cmd;
        p.beat.load_byte = data;
        command_queue.push_back(p);
        beats_queued++;
    endtask

    function automatic logic [7:0] pick_byte();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
        begin
            return GREY_MIN;
        end
        if (roll == 1)
        begin
            return GREY_MAX;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [CFG_W-1:0] raw_dim(int d);
        if (d == 1 && $urandom_range(0, 3) == 0)
        begin
            return '0;
        end
        if (d == DIM_MAX)
        begin
            return CFG_W'($urandom_range(256, 511));
        end
        return CFG_W'(d);
    endfunction

    task automatic wait_idle();
        do
            @(negedge clk);
        while (command_queue.size() != 0 || start || queued_outputs.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_IMAGE_WIDTH:  cfg_width  = data;
            CFG_IMAGE_HEIGHT: cfg_height = data;
            CFG_NIBBLE_MODE:  cfg_nibble = data[0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [CFG_W-1:0] w_raw, logic [CFG_W-1:0] h_raw,
                              logic mode);
        write_reg(CFG_IMAGE_WIDTH, w_raw);
        write_reg(CFG_IMAGE_HEIGHT, h_raw);
        write_reg(CFG_NIBBLE_MODE, {8'($urandom_range(0, 255)), mode});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic image_phase(phase_kind_t kind);
        logic mid;
        logic mode;
        logic full_fetch;
        int   cur_w;
        int   cur_h;
        int   w;
        int   h;
        int   stride;
        int   loads;
        int   fetches;
        int   n;
        mid   = img_full || ld_row != 0 || ld_col != 0;
        cur_w = eff_dim(cfg_width);
        cur_h = eff_dim(cfg_height);
        mode  = 1'($urandom_range(0, 1));
        if (mid)
        begin
            w = ($urandom_range(0, 9) < 7) ? $urandom_range(1, (cur_w < 8) ? cur_w : 8) : cur_w;
            h = ($urandom_range(0, 9) < 7) ? $urandom_range(1, (cur_h < 8) ? cur_h : 8) : cur_h;
        end
        else if (kind == PHASE_WIDE)
        begin
            w    = DIM_MAX;
            h    = 1;
            mode = 1'b1;
        end
        else if (kind == PHASE_TALL)
        begin
            w = 1;
            h = DIM_MAX;
        end
        else
        begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 8);
        end
        set_config(raw_dim(w), raw_dim(h), mode);
        gap_style = ($urandom_range(0, 3) == 0) ? 0 : 1;
        if (mid)
        begin
            n = $urandom_range(8, 40);
            repeat (n)
            begin
                push_beat(($urandom_range(0, 9) < 6) ? CMD_FETCH : CMD_LOAD, pick_byte(),
                          ($urandom_range(0, 49) == 0));
            end
            return;
        end
        stride  = mode ? 2 : 1;
        loads   = h * ((w + stride - 1) / stride);
        fetches = w * ((h + stride - 1) / stride);
        if (kind == PHASE_TALL)
        begin
            loads = $urandom_range(3, 8);
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            loads = $urandom_range(1, loads);
        end
        for (int i = 0; i < loads; i++)
        begin
            if ($urandom_range(0, 24) == 0)
            begin
                push_beat(CMD_FETCH, pick_byte(), 1'b0);
            end
            push_beat(CMD_LOAD, pick_byte(), ($urandom_range(0, 49) == 0));
        end
        if (loads < h * ((w + stride - 1) / stride))
        begin
            return;
        end
        n = $urandom_range(0, 2);
        repeat (n)
        begin
            push_beat(CMD_LOAD, pick_byte(), 1'b0);
        end
        full_fetch = ($urandom_range(0, 19) < 17);
        if (!full_fetch)
        begin
            fetches = $urandom_range(1, fetches);
        end
        for (int i = 0; i < fetches; i++)
        begin
            push_beat(CMD_FETCH, pick_byte(), ($urandom_range(0, 49) == 0));
        end
        if (full_fetch && $urandom_range(0, 2) == 0)
        begin
            push_beat(CMD_FETCH, pick_byte(), 1'b0);
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_IMAGE_WIDTH;
        cfg_data       <= '0;
        cfg_width       = SIZE_RESET;
        cfg_height      = SIZE_RESET;
        cfg_nibble      = 1'b0;
        ld_row          = 0;
        ld_col          = 0;
        em_row          = 0;
        em_col          = 0;
        img_full        = 1'b0;
        grey_lo         = GREY_MAX;
        grey_hi         = GREY_MIN;
        gap_style       = 1;
        mismatch_count  = 0;
        cycle_count     = 0;
        beats_queued    = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        push_beat(CMD_FETCH, 8'h00, 1'b0);
        wait_idle();

        set_config(9'd3, 9'd2, 1'b0);
        push_beat(CMD_LOAD, 8'h00, 1'b0);
        push_beat(CMD_LOAD, 8'hFF, 1'b0);
        push_beat(CMD_LOAD, 8'h80, 1'b0);
        push_beat(CMD_LOAD, 8'h7F, 1'b0);
        push_beat(CMD_LOAD, 8'h01, 1'b0);
        push_beat(CMD_LOAD, 8'h5A, 1'b0);
        push_beat(CMD_LOAD, 8'hA5, 1'b0);
        wait_idle();

        // The image stays loaded while the mode flips to nibble output.
        set_config(9'd3, 9'd2, 1'b1);
        repeat (4) push_beat(CMD_FETCH, 8'hFF, 1'b0);
        wait_idle();

        set_config(9'd3, 9'd3, 1'b1);
        push_beat(CMD_LOAD, 8'hF0, 1'b0);
        push_beat(CMD_LOAD, 8'h1E, 1'b0);
        push_beat(CMD_LOAD, 8'h0F, 1'b0);
        push_beat(CMD_LOAD, 8'hC3, 1'b0);
        push_beat(CMD_LOAD, 8'h96, 1'b0);
        push_beat(CMD_LOAD, 8'h69, 1'b0);
        repeat (6) push_beat(CMD_FETCH, 8'h00, 1'b0);
        wait_idle();

        set_config(9'd0, 9'd0, 1'b0);
        push_beat(CMD_LOAD, 8'h42, 1'b0);
        push_beat(CMD_FETCH, 8'h00, 1'b0);
        wait_idle();

        image_phase(PHASE_WIDE);
        wait_idle();
        image_phase(PHASE_TALL);
        wait_idle();
        while (beats_queued < BEAT_TARGET)
        begin
            image_phase(PHASE_SMALL);
            wait_idle();
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("image_transpose_buffer_top: match");
        end
        else
        begin
            $display("image_transpose_buffer_top: mismatch");
        end
        $finish;
    end
endmodule
